// File: rtl/vfc_pkg.sv
// shared constants, types and sine table function for the footprint collision checker
`timescale 1ns / 1ps
package vfc_pkg;

    // default sizes
    localparam int VFC_GRID_ROWS   = 64;
    localparam int VFC_GRID_COLS   = 64;
    localparam int VFC_ANGLE_STEPS = 1024;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_VEHICLE_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEHICLE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFETY_MARGIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLS       = 3'd4;

    // register reset values
    localparam logic [11:0] RST_VEHICLE_LENGTH = 12'd512;
    localparam logic [11:0] RST_VEHICLE_WIDTH  = 12'd256;
    localparam logic [9:0]  RST_SAFETY_MARGIN  = 10'd77;
    localparam logic [6:0]  RST_MAP_ROWS       = 7'd64;
    localparam logic [6:0]  RST_MAP_COLS       = 7'd64;

    // request kinds
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // sine table value width, Q1.14 magnitude 0..16384
    localparam int SIN_W = 15;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_TRIG,
        S_RDS,
        S_RDC,
        S_MUL,
        S_CORNER,
        S_DONE
    } t_state;

    // sin(x) in Q1.14 from a Q30 first-quadrant angle, Taylor terms through x^15
    function automatic logic [SIN_W-1:0] quarter_sin_q14(input logic [63:0] x);
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] rnd;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (n)
                1: term = term / 64'd6;
                2: term = term / 64'd20;
                3: term = term / 64'd42;
                4: term = term / 64'd72;
                5: term = term / 64'd110;
                6: term = term / 64'd156;
                default: term = term / 64'd210;
            endcase
            if (n % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        rnd = ($unsigned(sum) + 64'd32768) >> 16;
        return rnd[SIN_W-1:0];
    endfunction

endpackage

// File: rtl/vfc_sin_rom.sv
// first-quadrant sine table with registered read
`timescale 1ns / 1ps
module vfc_sin_rom
    import vfc_pkg::*;
#(
    parameter int ANGLE_STEPS = VFC_ANGLE_STEPS,
    localparam int UW = $clog2(ANGLE_STEPS + 1)
) (
    input  logic             i_clk,
    input  logic [UW-1:0]    i_addr,
    output logic [SIN_W-1:0] o_data
);

    logic [SIN_W-1:0] w_table [0:ANGLE_STEPS];
    logic [SIN_W-1:0] r_data;

    // table contents worked out at elaboration, one entry per quarter step
    for (genvar g = 0; g <= ANGLE_STEPS; g++) begin : g_entry
        localparam logic [63:0] XQ30 = (64'(g) * HALF_PI_Q30) / 64'(ANGLE_STEPS);
        assign w_table[g] = quarter_sin_q14(XQ30);
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_data <= w_table[i_addr];
    end

    assign o_data = r_data;

endmodule

// File: rtl/vehicle_footprint_collision_check.sv
// top level: occupancy grid memory, pose sequencer and corner checks
//
//  channel   dir  fields (low bit first)                                   done when
//  s_axis    in   tuser: op; tdata: cell_row, cell_col, cell_blocked,      tvalid & tready
//                 pose_x, pose_y, pose_heading
//  m_axis    out  tdata: collision                                         tvalid & tready
//  cfg       in   idx selects register, data written                       we high
//
//  A cell write goes from acceptance straight to the done state, which loads its result; a
//  pose check first runs the heading modulo and fold, two reads of the one sine ROM port,
//  four passes through the shared multiplier and four corner reads of the single-port
//  grid memory. A new request is taken only once the result is loaded. After reset the
//  grid memory is cleared one cell a cycle, all GRID_ROWS*GRID_COLS cells, while no
//  request is taken. A full output register stalls only the final step.
`timescale 1ns / 1ps
module vehicle_footprint_collision_check
    import vfc_pkg::*;
#(
    parameter int GRID_ROWS   = VFC_GRID_ROWS,
    parameter int GRID_COLS   = VFC_GRID_COLS,
    parameter int ANGLE_STEPS = VFC_ANGLE_STEPS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request in
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // cell_row[5:0] cell_col[11:6] cell_blocked[12] pose_x[29:13] pose_y[46:30]
    // pose_heading[56:47]
    input  logic [63:0]           i_s_axis_tdata,
    // op[0]
    input  logic                  i_s_axis_tuser,
    // result out
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // collision[0]
    output logic [7:0]            o_m_axis_tdata,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = GRID_ROWS * GRID_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int UW    = $clog2(ANGLE_STEPS + 1);
    localparam int TW    = $clog2(4 * ANGLE_STEPS);
    localparam int TW1   = TW + 1;
    localparam int CW    = 19;
    localparam int MOD_SHIFT = 24;
    localparam logic [18:0] MOD_RECIP =
        19'((2 ** MOD_SHIFT + ANGLE_STEPS - 1) / ANGLE_STEPS);
    localparam logic [TW1-1:0] T_1Q = TW1'(ANGLE_STEPS);
    localparam logic [TW1-1:0] T_2Q = TW1'(2 * ANGLE_STEPS);
    localparam logic [TW1-1:0] T_3Q = TW1'(3 * ANGLE_STEPS);
    localparam logic [TW1-1:0] T_4Q = TW1'(4 * ANGLE_STEPS);
    localparam logic [10:0] GRID_ROWS_L = 11'(GRID_ROWS);
    localparam logic [10:0] GRID_COLS_L = 11'(GRID_COLS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // state and control
    t_state r_state, n_state;
    logic [AW-1:0] r_clr;
    logic [1:0]    r_step;

    // configuration registers
    logic [11:0] r_len, r_wid;
    logic [9:0]  r_margin;
    logic [6:0]  r_map_rows, r_map_cols;

    // request fields
    logic               r_op;
    logic signed [16:0] r_x, r_y;
    logic [9:0]         r_h;

    // heading, trig and offsets
    logic [4:0]         r_q;
    logic [UW-1:0]      r_sin_u, r_cos_u;
    logic               r_sin_neg, r_cos_neg;
    logic signed [15:0] r_sin, r_cos;
    logic signed [13:0] r_fx, r_fy, r_hx, r_hy;

    // corner results
    logic r_hit, r_rd_pend;
    logic r_out_valid, r_out_coll;

    // grid memory
    logic          r_mem [0:DEPTH-1];
    logic          r_mem_q;
    logic          w_mem_we, w_mem_re, w_mem_wdata;
    logic [AW-1:0] w_mem_addr, w_wr_addr, w_rd_addr;

    logic w_in_ready, w_accept, w_out_free, w_coll;
    logic w_wr_in_grid;

    // ------------------------------------------------------------------
    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= RST_VEHICLE_LENGTH;
            r_wid      <= RST_VEHICLE_WIDTH;
            r_margin   <= RST_SAFETY_MARGIN;
            r_map_rows <= RST_MAP_ROWS;
            r_map_cols <= RST_MAP_COLS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VEHICLE_LENGTH: r_len      <= i_cfg_data[11:0];
                CFG_VEHICLE_WIDTH:  r_wid      <= i_cfg_data[11:0];
                CFG_SAFETY_MARGIN:  r_margin   <= i_cfg_data[9:0];
                CFG_MAP_ROWS:       r_map_rows <= i_cfg_data[6:0];
                CFG_MAP_COLS:       r_map_cols <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == LAST_ADDR) n_state = S_IDLE;
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_s_axis_tuser == OP_CHECK) ? S_MOD : S_DONE;
                end
            end
            S_MOD:    n_state = S_TRIG;
            S_TRIG:   n_state = S_RDS;
            S_RDS:    n_state = S_RDC;
            S_RDC:    n_state = S_MUL;
            S_MUL:    if (r_step == 2'd3) n_state = S_CORNER;
            S_CORNER: if (r_step == 2'd3) n_state = S_DONE;
            S_DONE:   if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_mem_re   = 1'b0;
        unique case (r_state)
            S_IDLE:   w_in_ready = 1'b1;
            S_CORNER: w_mem_re   = 1'b1;
            default: ;
        endcase
    end

    assign o_s_axis_tready = w_in_ready;
    assign w_accept        = i_s_axis_tvalid & w_in_ready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (r_state == S_MUL || r_state == S_CORNER) begin
                r_step <= r_step + 2'd1;
            end else begin
                r_step <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_s_axis_tuser;
            r_x  <= $signed(i_s_axis_tdata[29:13]);
            r_y  <= $signed(i_s_axis_tdata[46:30]);
            r_h  <= i_s_axis_tdata[56:47];
        end
    end

    // heading modulo the step count by reciprocal multiply
    logic [28:0] w_modp;
    assign w_modp = 29'(r_h) * 29'(MOD_RECIP);

    always_ff @(posedge i_clk) begin
        if (r_state == S_MOD) begin
            r_q <= w_modp[MOD_SHIFT+4:MOD_SHIFT];
        end
    end

    // quadrant folding of an angle in quarter steps
    function automatic logic [UW:0] fold(input logic [TW1-1:0] t);
        logic [TW1-1:0] u;
        logic           neg;
        if (t < T_1Q) begin
            u = t;          neg = 1'b0;
        end else if (t < T_2Q) begin
            u = T_2Q - t;   neg = 1'b0;
        end else if (t < T_3Q) begin
            u = t - T_2Q;   neg = 1'b1;
        end else begin
            u = T_4Q - t;   neg = 1'b1;
        end
        return {neg, u[UW-1:0]};
    endfunction

    logic [9:0]     w_qn, w_a;
    logic [TW1-1:0] w_ts, w_tc_raw, w_tc;
    logic [UW:0]    w_sin_f, w_cos_f;

    assign w_qn     = 10'(32'(r_q) * ANGLE_STEPS);
    assign w_a      = r_h - w_qn;
    assign w_ts     = TW1'(TW'(w_a)) << 2;
    assign w_tc_raw = w_ts + T_1Q;
    assign w_tc     = (w_tc_raw >= T_4Q) ? (w_tc_raw - T_4Q) : w_tc_raw;
    assign w_sin_f  = fold(w_ts);
    assign w_cos_f  = fold(w_tc);

    always_ff @(posedge i_clk) begin
        if (r_state == S_TRIG) begin
            r_sin_neg <= w_sin_f[UW];
            r_sin_u   <= w_sin_f[UW-1:0];
            r_cos_neg <= w_cos_f[UW];
            r_cos_u   <= w_cos_f[UW-1:0];
        end
    end

    // sine table: sine read first, cosine next
    logic [UW-1:0]      w_rom_addr;
    logic [SIN_W-1:0]   w_rom_q;
    logic signed [15:0] w_rom_mag;

    assign w_rom_addr = (r_state == S_RDC) ? r_cos_u : r_sin_u;

    vfc_sin_rom #(
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_sin_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_q)
    );

    assign w_rom_mag = $signed(16'(w_rom_q));

    always_ff @(posedge i_clk) begin
        if (r_state == S_RDC) begin
            r_sin <= r_sin_neg ? -w_rom_mag : w_rom_mag;
        end
        if (r_state == S_MUL && r_step == 2'd0) begin
            r_cos <= r_cos_neg ? -w_rom_mag : w_rom_mag;
        end
    end

    // shared multiplier: fy, hx, fx, hy in turn, rounded to nearest
    logic [12:0]        w_d, w_e;
    logic signed [13:0] w_len_op;
    logic signed [15:0] w_trig_op;
    logic signed [29:0] w_prod, w_rnd, w_sh;

    assign w_d       = 13'(r_len) + 13'(r_margin);
    assign w_e       = 13'(r_wid) + 13'(r_margin);
    assign w_len_op  = $signed({1'b0, (r_step[0] ? w_e : w_d)});
    assign w_trig_op = r_step[1] ? r_cos : r_sin;
    assign w_prod    = 30'(w_len_op) * 30'(w_trig_op);
    assign w_rnd     = w_prod + (r_step[0] ? 30'sd16384 : 30'sd8192);
    assign w_sh      = r_step[0] ? (w_rnd >>> 15) : (w_rnd >>> 14);

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            case (r_step)
                2'd0:    r_fy <= w_sh[13:0];
                2'd1:    r_hx <= w_sh[13:0];
                2'd2:    r_fx <= w_sh[13:0];
                default: r_hy <= w_sh[13:0];
            endcase
        end
    end

    // corner of this step: bit 1 picks front, bit 0 picks right side
    logic signed [CW-1:0] w_cx, w_cy;
    logic [9:0]           w_row, w_col;
    logic                 w_onmap;

    assign w_cx = CW'(r_x) + (r_step[1] ? CW'(r_fx) : CW'(0))
                + (r_step[0] ? CW'(r_hx) : -CW'(r_hx));
    assign w_cy = CW'(r_y) + (r_step[1] ? CW'(r_fy) : CW'(0))
                + (r_step[0] ? -CW'(r_hy) : CW'(r_hy));
    assign w_row = w_cx[17:8];
    assign w_col = w_cy[17:8];
    assign w_onmap = !w_cx[CW-1] && !w_cy[CW-1]
                   && (11'(w_row) < 11'(r_map_rows)) && (11'(w_row) < GRID_ROWS_L)
                   && (11'(w_col) < 11'(r_map_cols)) && (11'(w_col) < GRID_COLS_L);
    assign w_rd_addr = w_onmap ? AW'(32'(w_row) * GRID_COLS + 32'(w_col)) : '0;

    // collision flag, last corner read folded in at the end
    assign w_coll = r_hit | (r_rd_pend & r_mem_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit     <= 1'b0;
            r_rd_pend <= 1'b0;
        end else if (w_accept) begin
            r_hit     <= 1'b0;
            r_rd_pend <= 1'b0;
        end else if (r_state == S_CORNER) begin
            r_hit     <= w_coll | !w_onmap;
            r_rd_pend <= w_onmap;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_coll  <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
            r_out_coll  <= (r_op == OP_CHECK) & w_coll;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_coll};

    // ------------------------------------------------------------------
    // grid memory: clearing pass, cell writes, corner reads
    assign w_wr_in_grid = (11'(i_s_axis_tdata[5:0]) < GRID_ROWS_L)
                        && (11'(i_s_axis_tdata[11:6]) < GRID_COLS_L);
    assign w_wr_addr = (r_state == S_CLEAR) ? r_clr
                     : AW'(32'(i_s_axis_tdata[5:0]) * GRID_COLS + 32'(i_s_axis_tdata[11:6]));
    assign w_mem_we = (r_state == S_CLEAR)
                    || (w_accept && i_s_axis_tuser == OP_WRITE && w_wr_in_grid);
    assign w_mem_wdata = (r_state == S_CLEAR) ? 1'b0 : i_s_axis_tdata[12];
    assign w_mem_addr  = w_mem_re ? w_rd_addr : w_wr_addr;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_mem_q <= r_mem[w_mem_addr];
        end
    end

    // ------------------------------------------------------------------
    // checks
    a_port_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_we && w_mem_re))
        else $error("grid memory read and write in the same cycle");

    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_axis_tuser == OP_WRITE)
            |=> (r_state == S_DONE && !r_hit && !r_rd_pend))
        else $error("cell write did not go straight to a clean result");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result shown during the clearing pass");

    a_pend_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rd_pend) |-> $past(r_state == S_CORNER))
        else $error("corner read pending without a corner step");

endmodule
